// ----- rtl/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// RDP connection request parser package
// Shared status codes, queue sizing and the record that the parser hands to
// the output stage.
// ----------------------------------------------------------------------------
package rdp_pkg;

	// Status codes reported in the final item of a run.
	localparam logic [2:0] StOk         = 3'd0;
	localparam logic [2:0] StHdrShort   = 3'd1;
	localparam logic [2:0] StVersion    = 3'd2;
	localparam logic [2:0] StTooShort   = 3'd3;
	localparam logic [2:0] StPayShort   = 3'd4;
	localparam logic [2:0] StX224       = 3'd5;
	localparam logic [2:0] StNegReq     = 3'd6;

	// Protocol constants.
	localparam logic [7:0]  TpktVersion  = 8'h03;
	localparam logic [7:0]  X224CrCode   = 8'hE0;
	localparam logic [7:0]  X224ClassMsk = 8'hFC;
	localparam logic [7:0]  NegReqType   = 8'h01;
	localparam logic [7:0]  NegReqLen    = 8'h08;
	localparam int unsigned RdstlsBit    = 2;
	localparam logic [15:0] MinPktLen    = 16'd11;
	localparam logic [3:0]  PrefixLast   = 4'd12;
	localparam logic [7:0]  ChCr         = 8'h0D;
	localparam logic [7:0]  ChLf         = 8'h0A;

	// Result queue between the parser and the output stage.
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);

	// One parser step: an optional token byte followed by an optional status.
	typedef struct packed {
		logic       tok_vld;
		logic [7:0] tok_byte;
		logic       st_vld;
		logic [2:0] code;
		logic       has_token;
		logic       wants_rdstls;
	} rdp_rec_t;

	// Characters of the "Cookie: msts=" prefix by index.
	function automatic logic [7:0] cookie_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h43;
			4'd1:    ch = 8'h6F;
			4'd2:    ch = 8'h6F;
			4'd3:    ch = 8'h6B;
			4'd4:    ch = 8'h69;
			4'd5:    ch = 8'h65;
			4'd6:    ch = 8'h3A;
			4'd7:    ch = 8'h20;
			4'd8:    ch = 8'h6D;
			4'd9:    ch = 8'h73;
			4'd10:   ch = 8'h74;
			4'd11:   ch = 8'h73;
			4'd12:   ch = 8'h3D;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/rdp_connection_request_parser.sv -----
// ----------------------------------------------------------------------------
// RDP connection request parser
// Parses the TPKT header, X.224 connection request, routing token cookie and
// rdpNegReq of a client's first packet, streaming the token bytes and ending
// each run with a status item.
//
//   Channel  Dir  Handshake           Content
//   s_*      in   s_tvalid/s_tready   s_tdata[7:0] data byte, s_tlast end of data
//   m_*      out  m_tvalid/m_tready   m_tdata token byte or status, m_tuser status
//
// One input byte is accepted per cycle while the four-record queue has room.
// A byte that yields both a token byte and the status needs two output
// transfers; all other bytes yield at most one, so the output side sets the
// rate only after such bytes or when m_tready is held low.
// Reset is asynchronous and active low; the parser restarts at the header.
// The token stream runs one byte behind the input.
// ----------------------------------------------------------------------------
module rdp_connection_request_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] token_byte, [10:8] status_code,
	                               // [11] has_token, [12] wants_rdstls, [15:13] zero
	output logic        m_tuser    // [0] is_status
);

	logic              accept;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	rdp_pkg::rdp_rec_t wr_rec;
	rdp_pkg::rdp_rec_t rd_rec;

	assign s_tready = !full;
	assign accept   = s_tvalid & s_tready;

	// Byte parser.
	rdp_parse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_tdata),
		.end_of_data (s_tlast),
		.push        (push),
		.rec         (wr_rec)
	);

	// Record queue.
	rdp_rec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.full   (full),
		.empty  (empty)
	);

	// Output stage.
	rdp_emit_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_rec    (rd_rec),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/rdp_parse_front.sv -----
// ----------------------------------------------------------------------------
// RDP parser front end
// Per-byte state machine that walks the TPKT header, the X.224 connection
// request, the cookie prefix, the routing token and the rdpNegReq, and builds
// at most one result record per accepted byte.
// ----------------------------------------------------------------------------
module rdp_parse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_data,
	output logic             push,
	output rdp_pkg::rdp_rec_t rec
);

	// Parse phases.
	localparam logic [2:0] PhHeader    = 3'd0;
	localparam logic [2:0] PhX224      = 3'd1;
	localparam logic [2:0] PhPrefix    = 3'd2;
	localparam logic [2:0] PhToken     = 3'd3;
	localparam logic [2:0] PhNegReq    = 3'd4;
	localparam logic [2:0] PhTailToken = 3'd5;
	localparam logic [2:0] PhTailNone  = 3'd6;
	localparam logic [2:0] PhDrain     = 3'd7;

	logic [15:0] pos_q, pos_n;
	logic [15:0] plen_q, plen_n;
	logic [2:0]  ph_q, ph_n;
	logic [3:0]  pidx_q, pidx_n;
	logic [7:0]  held_q, held_n;
	logic        hv_q, hv_n;
	logic [2:0]  perr_q, perr_n;
	logic        tnz_q, tnz_n;
	logic [15:0] nst_q, nst_n;
	logic        rds_q, rds_n;

	logic [16:0] pos1;
	logic [16:0] pos9;
	logic [15:0] plen_v;
	logic [15:0] off;
	logic        tail;
	logic        done;
	logic [2:0]  code_e;
	logic        has_e;

	// Next state for one accepted byte.
	always_comb begin
		pos_n  = pos_q;
		plen_n = plen_q;
		ph_n   = ph_q;
		pidx_n = pidx_q;
		held_n = held_q;
		hv_n   = hv_q;
		perr_n = perr_q;
		tnz_n  = tnz_q;
		nst_n  = nst_q;
		rds_n  = rds_q;
		rec    = '0;
		tail   = 1'b0;
		done   = 1'b0;
		code_e = rdp_pkg::StOk;
		has_e  = 1'b0;
		pos1   = {1'b0, pos_q} + 17'd1;
		pos9   = {1'b0, pos_q} + 17'd9;
		plen_v = {plen_q[15:8], data_byte};
		off    = pos_q - nst_q;

		case (ph_q)
			PhDrain: begin
				if (end_of_data) begin
					ph_n = PhHeader;
				end
			end
			PhHeader: begin
				if (pos_q == 16'd0 && data_byte != rdp_pkg::TpktVersion) begin
					perr_n = rdp_pkg::StVersion;
				end
				if (pos_q == 16'd2) begin
					plen_n = {data_byte, 8'h00};
				end
				if (pos_q < 16'd3) begin
					pos_n = pos1[15:0];
					if (end_of_data) begin
						done   = 1'b1;
						code_e = rdp_pkg::StHdrShort;
					end
				end else begin
					plen_n = plen_v;
					if (perr_q != rdp_pkg::StOk) begin
						done   = 1'b1;
						code_e = rdp_pkg::StVersion;
					end else if (plen_v < rdp_pkg::MinPktLen) begin
						done   = 1'b1;
						code_e = rdp_pkg::StTooShort;
					end else begin
						ph_n = PhX224;
						tail = 1'b1;
					end
				end
			end
			PhX224: begin
				tail = 1'b1;
				if (pos_q == 16'd4 && (plen_q - 16'd5) != {8'h00, data_byte}) begin
					perr_n = rdp_pkg::StX224;
				end
				if (pos_q == 16'd5 && data_byte != rdp_pkg::X224CrCode) begin
					perr_n = rdp_pkg::StX224;
				end
				if ((pos_q == 16'd6 || pos_q == 16'd7) && data_byte != 8'h00) begin
					perr_n = rdp_pkg::StX224;
				end
				if (pos_q == 16'd10) begin
					if ((data_byte & rdp_pkg::X224ClassMsk) != 8'h00) begin
						perr_n = rdp_pkg::StX224;
					end
					ph_n = (perr_n != rdp_pkg::StOk) ? PhTailNone : PhPrefix;
				end
			end
			PhPrefix: begin
				tail = 1'b1;
				if (data_byte == rdp_pkg::cookie_char(pidx_q)) begin
					pidx_n = pidx_q + 4'd1;
					if (pidx_q == rdp_pkg::PrefixLast) begin
						ph_n = PhToken;
					end
				end else begin
					ph_n = PhTailNone;
				end
			end
			PhToken: begin
				tail = 1'b1;
				if (hv_q && held_q == rdp_pkg::ChCr && data_byte == rdp_pkg::ChLf) begin
					hv_n   = 1'b0;
					held_n = 8'h00;
					if (!tnz_q) begin
						ph_n = PhTailNone;
					end else if (pos9 <= {1'b0, plen_q}) begin
						nst_n = pos1[15:0];
						ph_n  = PhNegReq;
					end else begin
						ph_n = PhTailToken;
					end
				end else begin
					// The held byte is released once the next one proves it is no CR of CRLF.
					if (hv_q) begin
						rec.tok_vld  = 1'b1;
						rec.tok_byte = held_q;
						tnz_n        = 1'b1;
					end
					held_n = data_byte;
					hv_n   = 1'b1;
				end
			end
			PhNegReq: begin
				tail = 1'b1;
				if (off == 16'd0 && data_byte != rdp_pkg::NegReqType) begin
					perr_n = rdp_pkg::StNegReq;
				end
				if (off == 16'd2 && data_byte != rdp_pkg::NegReqLen) begin
					perr_n = rdp_pkg::StNegReq;
				end
				if (off == 16'd3 && data_byte != 8'h00) begin
					perr_n = rdp_pkg::StNegReq;
				end
				if (off == 16'd4) begin
					rds_n = data_byte[rdp_pkg::RdstlsBit];
				end
				if (off >= 16'd7) begin
					ph_n = PhTailToken;
				end
			end
			PhTailToken: begin
				tail = 1'b1;
			end
			PhTailNone: begin
				tail = 1'b1;
			end
			default: begin
				ph_n = PhHeader;
			end
		endcase

		// End of packet or end of available data.
		if (tail) begin
			pos_n = pos1[15:0];
			if (pos1 == {1'b0, plen_n}) begin
				done   = 1'b1;
				code_e = perr_n;
				has_e  = (perr_n == rdp_pkg::StOk) && (ph_n == PhTailToken);
			end else if (end_of_data) begin
				done   = 1'b1;
				code_e = rdp_pkg::StPayShort;
			end
		end

		// Status item and run restart.
		if (done) begin
			rec.st_vld       = 1'b1;
			rec.code         = code_e;
			rec.has_token    = has_e;
			rec.wants_rdstls = has_e & rds_n;
			pos_n  = 16'd0;
			plen_n = 16'd0;
			pidx_n = 4'd0;
			held_n = 8'h00;
			hv_n   = 1'b0;
			perr_n = rdp_pkg::StOk;
			tnz_n  = 1'b0;
			nst_n  = 16'd0;
			rds_n  = 1'b0;
			ph_n   = end_of_data ? PhHeader : PhDrain;
		end
	end

	assign push = accept & (rec.tok_vld | rec.st_vld);

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 16'd0;
			plen_q <= 16'd0;
			ph_q   <= PhHeader;
			pidx_q <= 4'd0;
			held_q <= 8'h00;
			hv_q   <= 1'b0;
			perr_q <= rdp_pkg::StOk;
			tnz_q  <= 1'b0;
			nst_q  <= 16'd0;
			rds_q  <= 1'b0;
		end else if (accept) begin
			pos_q  <= pos_n;
			plen_q <= plen_n;
			ph_q   <= ph_n;
			pidx_q <= pidx_n;
			held_q <= held_n;
			hv_q   <= hv_n;
			perr_q <= perr_n;
			tnz_q  <= tnz_n;
			nst_q  <= nst_n;
			rds_q  <= rds_n;
		end
	end

endmodule

// ----- rtl/rdp_rec_fifo.sv -----
// ----------------------------------------------------------------------------
// RDP result record queue
// Short first-in first-out queue of parser records that lets the parser and
// the output stage stall independently.
// ----------------------------------------------------------------------------
module rdp_rec_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rdp_pkg::rdp_rec_t wr_rec,
	input  logic              pop,
	output rdp_pkg::rdp_rec_t rd_rec,
	output logic              full,
	output logic              empty
);

	localparam int unsigned Aw = rdp_pkg::FifoAw;

	rdp_pkg::rdp_rec_t       slot_q [rdp_pkg::FifoDepth];
	logic [Aw-1:0]           wp_q;
	logic [Aw-1:0]           rp_q;
	logic [Aw:0]             cnt_q;

	assign full   = (cnt_q == (Aw+1)'(rdp_pkg::FifoDepth));
	assign empty  = (cnt_q == '0);
	assign rd_rec = slot_q[rp_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + Aw'(1);
			end
			if (pop) begin
				rp_q <= rp_q + Aw'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Aw+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Aw+1)'(1);
			end
		end
	end

	// The parser never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("record queue overflow");

	// The output stage never reads an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("record queue underflow");

	// A lone write raises the fill count by one.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (Aw+1)'(1))
		else $error("record queue count did not advance");

endmodule

// ----- rtl/rdp_emit_back.sv -----
// ----------------------------------------------------------------------------
// RDP result output stage
// Takes records from the queue and presents their token and status items on
// the output stream, one item per transfer, token first.
// ----------------------------------------------------------------------------
module rdp_emit_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  rdp_pkg::rdp_rec_t q_rec,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tuser
);

	rdp_pkg::rdp_rec_t rec_q;
	logic              tok_pend_q;
	logic              st_pend_q;
	logic              xfer;
	logic              last_xfer;

	assign m_tvalid  = tok_pend_q | st_pend_q;
	assign xfer      = m_tvalid & m_tready;
	// The transfer empties the holding register when only one item is left.
	assign last_xfer = xfer & (tok_pend_q ^ st_pend_q);
	assign pop       = !q_empty & (!m_tvalid | last_xfer);

	// Item on the bus: token byte, or the status fields with a zero byte.
	assign m_tuser = !tok_pend_q;
	assign m_tdata = tok_pend_q
		? {8'h00, rec_q.tok_byte}
		: {3'b000, rec_q.wants_rdstls, rec_q.has_token, rec_q.code, 8'h00};

	// Holding register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_rec;
		end
	end

	// Pending item flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_pend_q <= 1'b0;
			st_pend_q  <= 1'b0;
		end else if (pop) begin
			tok_pend_q <= q_rec.tok_vld;
			st_pend_q  <= q_rec.st_vld;
		end else if (xfer) begin
			if (tok_pend_q) begin
				tok_pend_q <= 1'b0;
			end else begin
				st_pend_q <= 1'b0;
			end
		end
	end

endmodule
